@@ rtl/core/puc_pkg.sv @@
// Package for the polyphase upchannelizer: sizes, control types and the
// coefficient ROM contents, built at elaboration. No dependencies.
package puc_pkg;

  localparam int PUC_TAPS   = 4;
  localparam int PUC_FACTOR = 8;
  localparam int PUC_POLS   = 2;
  localparam int PUC_LANES  = 4;
  localparam int PUC_NTAP   = PUC_TAPS * PUC_FACTOR;
  localparam int PUC_NGAIN  = 8;
  localparam int PUC_SW     = $clog2(PUC_NTAP);
  localparam int PUC_UW     = 3;
  localparam int PUC_CW     = $clog2(PUC_NTAP + 1);
  localparam int PUC_AW     = $clog2(PUC_POLS * PUC_NTAP);
  localparam int PUC_ACCW   = 38;
  localparam int PUC_SPW    = PUC_ACCW + 16;
  localparam int PUC_RSH    = 27;

  localparam longint unsigned PUC_PI_Q30  = 64'd3373259426;
  localparam longint unsigned PUC_ONE_Q30 = 64'd1073741824;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_SCALE,
    ST_ROUND,
    ST_EMIT
  } puc_state_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic prod_en;
    logic acc_clr;
    logic acc_en;
    logic scale_en;
    logic round_en;
  } puc_ctl_t;

  typedef logic [31:0] puc_coef_tab_t [PUC_FACTOR * PUC_NTAP];

  // shift-subtract quotient, used only while building the tables
  function automatic longint unsigned udiv64(longint unsigned a, longint unsigned b);
    longint unsigned q, r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // signed quotient truncated toward zero, positive divisor
  function automatic longint sdiv_pos(longint a, longint b);
    longint unsigned qm;
    qm = udiv64((a < 0) ? unsigned'(-a) : unsigned'(a), unsigned'(b));
    return (a < 0) ? -longint'(qm) : longint'(qm);
  endfunction

  function automatic longint round_even(longint v, int sh);
    longint unsigned m, q, r, half;
    logic neg;
    neg = (v < 0);
    m = neg ? longint'(-v) : longint'(v);
    if (sh == 0) return v;
    q = m >> sh;
    r = m & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (r > half || (r == half && q[0])) q = q + 64'd1;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // {sin, cos} of n/d turns, Q30, truncating Taylor series
  function automatic logic [127:0] trig_pair(longint n, longint d);
    longint r, q, rem, s, c, so, co;
    longint unsigned x, x2, ts, tc, an, ar;
    an = (n < 0) ? unsigned'(-n) : unsigned'(n);
    ar = an - udiv64(an, unsigned'(d)) * unsigned'(d);
    r = (n < 0) ? -longint'(ar) : longint'(ar);
    if (r < 0) r = r + d;
    q = longint'(udiv64(unsigned'(4 * r), unsigned'(d)));
    rem = 4 * r - q * d;
    x = udiv64(unsigned'(rem) * PUC_PI_Q30, unsigned'(2 * d));
    x2 = (x * x) >> 30;
    ts = x;
    tc = PUC_ONE_Q30;
    s = longint'(x);
    c = longint'(PUC_ONE_Q30);
    for (int k = 1; k <= 9; k++) begin
      ts = udiv64((ts * x2) >> 30, 64'((2 * k) * (2 * k + 1)));
      tc = udiv64((tc * x2) >> 30, 64'((2 * k - 1) * (2 * k)));
      if (k % 2 == 1) begin
        s = s - longint'(ts);
        c = c - longint'(tc);
      end else begin
        s = s + longint'(ts);
        c = c + longint'(tc);
      end
    end
    case (q)
      0: begin so = s; co = c; end
      1: begin so = c; co = -s; end
      2: begin so = -s; co = -c; end
      default: begin so = -c; co = s; end
    endcase
    return {so, co};
  endfunction

  function automatic puc_coef_tab_t build_coef();
    puc_coef_tab_t tab;
    longint k, ak, sn, cs, sy, sinc, w, n, pr, pi, cr, ci;
    longint unsigned mc, c2, m;
    logic [127:0] tp;
    for (int s = 0; s < PUC_NTAP; s++) begin
      k = 2 * s - PUC_NTAP + 1;
      ak = (k < 0) ? -k : k;
      tp = trig_pair(ak, 4 * PUC_NTAP);
      cs = longint'(tp[63:0]);
      mc = (cs < 0) ? longint'(-cs) : longint'(cs);
      c2 = (mc * mc) >> 30;
      if (ak == 0) begin
        sinc = longint'(64'd1 << 28);
      end else begin
        tp = trig_pair(ak, 4 * PUC_FACTOR);
        sy = longint'(tp[127:64]);
        m = (sy < 0) ? longint'(-sy) : longint'(sy);
        m = udiv64((m * longint'(2 * PUC_FACTOR)) << 28, longint'(ak) * PUC_PI_Q30);
        sinc = (sy < 0) ? -longint'(m) : longint'(m);
      end
      w = sat16(round_even(sdiv_pos(longint'(c2) * sinc, PUC_FACTOR), 43));
      for (int u = 0; u < PUC_FACTOR; u++) begin
        n = -(2 * u - PUC_FACTOR + 1) * s;
        tp = trig_pair(n, 2 * PUC_FACTOR);
        sn = longint'(tp[127:64]);
        cs = longint'(tp[63:0]);
        pr = sat16(round_even(cs, 15));
        pi = sat16(round_even(sn, 15));
        cr = sat16(round_even(w * pr, 15));
        ci = sat16(round_even(w * pi, 15));
        tab[u * PUC_NTAP + s] = {cr[15:0], ci[15:0]};
      end
    end
    return tab;
  endfunction

  localparam puc_coef_tab_t PUC_COEF = build_coef();

endpackage

@@ rtl/core/puc_if.sv @@
// Valid/ready channel interfaces for the upchannelizer input and result words.
// Depends on nothing.
interface puc_in_if;
  logic               valid;
  logic               ready;
  logic               pol;
  logic signed [15:0] in_re0, in_im0, in_re1, in_im1;
  logic signed [15:0] in_re2, in_im2, in_re3, in_im3;
  modport source (output valid, pol, in_re0, in_im0, in_re1, in_im1,
                  in_re2, in_im2, in_re3, in_im3, input ready);
  modport sink   (input valid, pol, in_re0, in_im0, in_re1, in_im1,
                  in_re2, in_im2, in_re3, in_im3, output ready);
endinterface

interface puc_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         channel;
  logic               out_pol;
  logic signed [15:0] out_re0, out_im0, out_re1, out_im1;
  logic signed [15:0] out_re2, out_im2, out_re3, out_im3;
  logic               last;
  modport source (output valid, channel, out_pol, out_re0, out_im0, out_re1, out_im1,
                  out_re2, out_im2, out_re3, out_im3, last, input ready);
  modport sink   (input valid, channel, out_pol, out_re0, out_im0, out_re1, out_im1,
                  out_re2, out_im2, out_re3, out_im3, last, output ready);
endinterface

@@ rtl/core/puc_lane.sv @@
// One dish lane: sample history RAM, complex MAC, gain scale, round and saturate.
// Depends on puc_pkg.
module puc_lane import puc_pkg::*; (
  input  logic                     clk_i,
  input  puc_ctl_t                 ctl_i,
  input  logic [PUC_AW-1:0]        wr_addr_i,
  input  logic [31:0]              wr_data_i,
  input  logic [PUC_AW-1:0]        rd_addr_i,
  input  logic [31:0]              coef_i,
  input  logic signed [15:0]       gain_i,
  output logic signed [15:0]       re_o,
  output logic signed [15:0]       im_o
);

  logic [31:0] mem [PUC_POLS * PUC_NTAP];
  logic [31:0] rd_q;
  logic signed [31:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [PUC_ACCW-1:0] acc_re_q, acc_im_q;
  logic signed [PUC_SPW-1:0] sp_re_q, sp_im_q;
  logic signed [15:0] res_re_q, res_im_q;
  logic signed [15:0] cr, ci, er, ei;

  assign cr = coef_i[31:16];
  assign ci = coef_i[15:0];
  assign er = rd_q[31:16];
  assign ei = rd_q[15:0];

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) mem[wr_addr_i] <= wr_data_i;
    if (ctl_i.rd_en) rd_q <= mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.prod_en) begin
      p_rr_q <= cr * er;
      p_ii_q <= ci * ei;
      p_ri_q <= cr * ei;
      p_ir_q <= ci * er;
    end
    if (ctl_i.acc_clr) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (ctl_i.acc_en) begin
      acc_re_q <= acc_re_q + PUC_ACCW'(p_rr_q) - PUC_ACCW'(p_ii_q);
      acc_im_q <= acc_im_q + PUC_ACCW'(p_ri_q) + PUC_ACCW'(p_ir_q);
    end
    if (ctl_i.scale_en) begin
      sp_re_q <= PUC_SPW'(acc_re_q) * PUC_SPW'(gain_i);
      sp_im_q <= PUC_SPW'(acc_im_q) * PUC_SPW'(gain_i);
    end
    if (ctl_i.round_en) begin
      res_re_q <= rnd_sat(sp_re_q);
      res_im_q <= rnd_sat(sp_im_q);
    end
  end

  // floor plus half-even fix-up equals symmetric half-even rounding
  function automatic logic signed [15:0] rnd_sat(logic signed [PUC_SPW-1:0] v);
    logic signed [PUC_SPW-1:0] fl;
    logic [PUC_RSH-1:0] r;
    logic inc;
    fl = v >>> PUC_RSH;
    r = v[PUC_RSH-1:0];
    inc = (r > {1'b1, {(PUC_RSH-1){1'b0}}}) ||
          ((r == {1'b1, {(PUC_RSH-1){1'b0}}}) && fl[0]);
    fl = fl + PUC_SPW'(inc);
    if (fl > PUC_SPW'(32767)) return 16'sh7fff;
    if (fl < -PUC_SPW'(32768)) return 16'sh8000;
    return fl[15:0];
  endfunction

  assign re_o = res_re_q;
  assign im_o = res_im_q;

endmodule

@@ rtl/core/puc_merge.sv @@
// Output stage: gathers the lane results with channel tags into one result word.
// Depends on puc_pkg and puc_if.
module puc_merge import puc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               ld_i,
  input  logic [PUC_UW-1:0]  channel_i,
  input  logic               pol_i,
  input  logic               last_i,
  input  logic signed [15:0] re_i [PUC_LANES],
  input  logic signed [15:0] im_i [PUC_LANES],
  output logic               free_o,
  puc_out_if.source          out_o
);

  logic valid_q;
  logic [PUC_UW-1:0] channel_q;
  logic pol_q, last_q;
  logic signed [15:0] re_q [PUC_LANES];
  logic signed [15:0] im_q [PUC_LANES];

  assign free_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= ld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i && free_o) begin
      channel_q <= channel_i;
      pol_q     <= pol_i;
      last_q    <= last_i;
      re_q      <= re_i;
      im_q      <= im_i;
    end
  end

  assign out_o.valid   = valid_q;
  assign out_o.channel = channel_q;
  assign out_o.out_pol = pol_q;
  assign out_o.last    = last_q;
  assign out_o.out_re0 = re_q[0];
  assign out_o.out_im0 = im_q[0];
  assign out_o.out_re1 = re_q[1];
  assign out_o.out_im1 = im_q[1];
  assign out_o.out_re2 = re_q[2];
  assign out_o.out_im2 = im_q[2];
  assign out_o.out_re3 = re_q[3];
  assign out_o.out_im3 = im_q[3];

endmodule

@@ rtl/core/polyphase_upchannelizer_top.sv @@
// Polyphase filter bank upchannelizer top level: sequencer, gain registers,
// coefficient ROM read, lane array and output merge. Depends on puc_pkg, puc_if,
// puc_lane and puc_merge.
//
// Usage:
//  - in_i carries one time sample word: polarization plus four complex lanes.
//    A sample is written into that polarization's 32-deep circular history;
//    ready is high only while the sequencer is idle.
//  - When a polarization has a full window (first after 32 samples, then after
//    every 8 more), the block runs 8 fine channels. Each channel runs a MAC over
//    all 32 taps (one complex MAC per lane per cycle, set by the single history
//    RAM read port per lane), a pipeline drain, one gain multiply, one
//    round/saturate and one hand-off.
//  - out_o gives one word per fine channel in channel order; last marks channel 7.
//    If the receiver stalls, the sequencer holds in the hand-off step until the
//    output register frees; nothing is dropped.
//  - cfg_we_i/cfg_idx_i/cfg_data_i write the Q4.12 channel gains (index = channel);
//    write them only while the block is idle (the block does not enforce this).
//  - Reset clears the sample counts, pointers and gains (to 1.0); the history RAM
//    is not cleared since a window is always full before it is read.
module polyphase_upchannelizer_top import puc_pkg::*; #(
  parameter int LANES = PUC_LANES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  puc_in_if.sink      in_i,
  puc_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  puc_state_e state_q, state_d;
  logic [PUC_UW-1:0] u_q;
  logic [PUC_SW-1:0] s_q, base_q;
  logic run_pol_q;
  logic [PUC_CW-1:0] seen_q [PUC_POLS];
  logic [PUC_SW-1:0] ptr_q [PUC_POLS];
  logic signed [15:0] gain_q [PUC_NGAIN];
  logic v1_q, v2_q;
  logic [31:0] coef_q;
  logic in_acc, run_start, merge_free, ld;
  puc_ctl_t ctl;
  logic [PUC_AW-1:0] wr_addr, rd_addr;
  logic signed [15:0] in_re [PUC_LANES];
  logic signed [15:0] in_im [PUC_LANES];
  logic signed [15:0] res_re [PUC_LANES];
  logic signed [15:0] res_im [PUC_LANES];

  assign in_acc    = in_i.valid && in_i.ready;
  assign run_start = in_acc && (seen_q[in_i.pol] == PUC_CW'(PUC_NTAP - 1));
  assign in_i.ready = (state_q == ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (run_start) state_d = ST_MAC;
      ST_MAC:   if (s_q == PUC_SW'(PUC_NTAP - 1)) state_d = ST_DRAIN;
      ST_DRAIN: if (!v1_q && !v2_q) state_d = ST_SCALE;
      ST_SCALE: state_d = ST_ROUND;
      ST_ROUND: state_d = ST_EMIT;
      ST_EMIT: begin
        if (merge_free) begin
          state_d = (u_q == PUC_UW'(PUC_FACTOR - 1)) ? ST_IDLE : ST_MAC;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // lane control
  always_comb begin
    ctl = '0;
    ld  = 1'b0;
    case (state_q)
      ST_IDLE:  ctl.wr_en = in_acc;
      ST_MAC: begin
        ctl.rd_en   = 1'b1;
        ctl.acc_clr = (s_q == '0);
      end
      ST_SCALE: ctl.scale_en = 1'b1;
      ST_ROUND: ctl.round_en = 1'b1;
      ST_EMIT:  ld = 1'b1;
      default:  ctl = '0;
    endcase
    ctl.prod_en = v1_q;
    ctl.acc_en  = v2_q;
  end

  assign wr_addr = {in_i.pol, ptr_q[in_i.pol]};
  assign rd_addr = {run_pol_q, PUC_SW'(base_q + s_q)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      u_q       <= '0;
      s_q       <= '0;
      base_q    <= '0;
      run_pol_q <= 1'b0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      for (int p = 0; p < PUC_POLS; p++) begin
        seen_q[p] <= '0;
        ptr_q[p]  <= '0;
      end
      for (int g = 0; g < PUC_NGAIN; g++) gain_q[g] <= 16'sd4096;
    end else begin
      state_q <= state_d;
      v1_q    <= ctl.rd_en;
      v2_q    <= v1_q;
      if (cfg_we_i) gain_q[cfg_idx_i] <= cfg_data_i;
      if (in_acc) begin
        ptr_q[in_i.pol] <= ptr_q[in_i.pol] + 1'b1;
        if (run_start) begin
          seen_q[in_i.pol] <= PUC_CW'(PUC_NTAP - PUC_FACTOR);
          run_pol_q        <= in_i.pol;
          base_q           <= ptr_q[in_i.pol] + 1'b1;
          u_q              <= '0;
          s_q              <= '0;
        end else begin
          seen_q[in_i.pol] <= seen_q[in_i.pol] + 1'b1;
        end
      end
      if (state_q == ST_MAC) s_q <= s_q + 1'b1;
      if (state_q == ST_EMIT && merge_free) u_q <= u_q + 1'b1;
    end
  end

  // coefficient ROM, one read per MAC cycle shared by all lanes
  always_ff @(posedge clk_i) begin
    if (ctl.rd_en) coef_q <= PUC_COEF[{u_q, s_q}];
  end

  always_comb begin
    in_re[0] = in_i.in_re0;  in_im[0] = in_i.in_im0;
    in_re[1] = in_i.in_re1;  in_im[1] = in_i.in_im1;
    in_re[2] = in_i.in_re2;  in_im[2] = in_i.in_im2;
    in_re[3] = in_i.in_re3;  in_im[3] = in_i.in_im3;
  end

  for (genvar l = 0; l < PUC_LANES; l++) begin : g_lane
    if (l < LANES) begin : g_on
      puc_lane u_lane (
        .clk_i     (clk_i),
        .ctl_i     (ctl),
        .wr_addr_i (wr_addr),
        .wr_data_i ({in_re[l], in_im[l]}),
        .rd_addr_i (rd_addr),
        .coef_i    (coef_q),
        .gain_i    (gain_q[u_q]),
        .re_o      (res_re[l]),
        .im_o      (res_im[l])
      );
    end else begin : g_off
      assign res_re[l] = '0;
      assign res_im[l] = '0;
    end
  end

  puc_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ld_i      (ld),
    .channel_i (u_q),
    .pol_i     (run_pol_q),
    .last_i    (u_q == PUC_UW'(PUC_FACTOR - 1)),
    .re_i      (res_re),
    .im_i      (res_im),
    .free_o    (merge_free),
    .out_o     (out_o)
  );

  // a run only starts from idle, with no MAC still in flight
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (!v1_q && !v2_q))
    else $error("sample accepted during a MAC run");

  // the last word of a run returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ld && merge_free && u_q == PUC_UW'(PUC_FACTOR - 1)) |=> (state_q == ST_IDLE))
    else $error("sequencer did not return to idle after last channel");

  // window counts stay below a full window while idle
  a_seen_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (seen_q[0] < PUC_CW'(PUC_NTAP) && seen_q[1] < PUC_CW'(PUC_NTAP)))
    else $error("sample count out of range");

endmodule
